// ===== rtl/mhtq_pkg.sv =====
// Shared types, sizes and codes for the min-heap timer queue.
// Used by the level cell, controller, top level and testbench; no dependencies.
package mhtq_pkg;

  localparam int CAPACITY   = 64;
  localparam int ID_COUNT   = 256;
  localparam int TIME_BITS  = 32;
  localparam int ID_BITS    = 8;
  localparam int CMD_BITS   = 2;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int NODE_W     = CNT_W;
  localparam int NUM_LEVELS = $clog2(CAPACITY + 1);
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int FLAG_AW    = $clog2(ID_COUNT);

  localparam logic [CMD_BITS-1:0] CMD_ADD    = CMD_BITS'(0);
  localparam logic [CMD_BITS-1:0] CMD_CANCEL = CMD_BITS'(1);
  localparam logic [CMD_BITS-1:0] CMD_TICK   = CMD_BITS'(2);

  typedef enum logic {
    OP_INS,
    OP_SIFT
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACK,
    S_WAIT,
    S_TCHK,
    S_FETCH,
    S_INJ,
    S_POP,
    S_CLR
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [ID_BITS-1:0]   ident;
  } entry_t;

  // Work item walking down the level chain.
  // Insert: m is the path node at this level, mfin the new leaf, sh levels left.
  // Sift: m is the hole one level up, n the number of entries held.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic              started;
    logic [LVL_W-1:0]  sh;
    logic [NODE_W-1:0] m;
    logic [NODE_W-1:0] mfin;
    logic [CNT_W-1:0]  n;
    entry_t            e;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic              side;
    logic [NODE_W-1:0] pair;
    entry_t            node;
  } wreq_t;

  typedef struct packed {
    logic [NODE_W-1:0] raddr;
    wreq_t             wr;
  } ramreq_t;

  function automatic logic [LVL_W-1:0] lvl_of(input logic [NODE_W-1:0] m);
    logic [LVL_W-1:0] l;
    l = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (m[i]) begin
        l = LVL_W'(i);
      end
    end
    return l;
  endfunction

endpackage

// ===== rtl/mhtq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mhtq_cell.sv =====
// One heap level: drives the two RAMs (left, right) that hold the level's sibling pairs
// and advances insert and sift-down work one level per cycle. Uses mhtq_pkg.
module mhtq_cell
  import mhtq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tok_t              tok_in,
  output tok_t              tok_out,
  input  wreq_t             up_in,
  output wreq_t             up_out,
  output ramreq_t           ram,
  input  entry_t            rd_left,
  input  entry_t            rd_right,
  input  logic [NODE_W-1:0] probe_m,
  output entry_t            probe_node,
  output logic              done
);

  tok_t                tok_r;
  logic                tok_vld_r;
  logic                pside_r;
  wreq_t               own_wr;
  entry_t              node_x;
  entry_t              child;
  logic                swap;
  logic                has_l;
  logic                has_r;
  logic                use_r;
  logic [NODE_W+1:0]   ext_m;
  logic [NODE_W+1:0]   ext_n;
  logic [NODE_W-1:0]   c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r   <= tok_in;
    pside_r <= probe_m[0];
  end

  always_comb begin
    if (tok_in.valid) begin
      ram.raddr = (tok_in.op == OP_INS) ? (tok_in.m >> 1) : tok_in.m;
    end else begin
      ram.raddr = probe_m >> 1;
    end
    ram.wr = own_wr.en ? own_wr : up_in;
  end

  assign probe_node = pside_r ? rd_right : rd_left;

  assign ext_m = (NODE_W + 2)'(tok_r.m);
  assign ext_n = (NODE_W + 2)'(tok_r.n);
  assign has_l = (ext_m << 1) <= ext_n;
  assign has_r = ((ext_m << 1) + (NODE_W + 2)'(1)) <= ext_n;
  assign use_r = has_r && (rd_right.expiry < rd_left.expiry);
  assign child = use_r ? rd_right : rd_left;
  assign c     = NODE_W'((ext_m << 1) + (NODE_W + 2)'(use_r));
  assign node_x = tok_r.m[0] ? rd_right : rd_left;
  assign swap  = tok_r.started || (node_x.expiry > tok_r.e.expiry);

  always_comb begin
    own_wr  = '0;
    up_out  = '0;
    tok_out = '0;
    done    = 1'b0;
    if (tok_vld_r) begin
      case (tok_r.op)
        OP_INS: begin
          if (tok_r.sh == '0) begin
            own_wr.en   = 1'b1;
            own_wr.side = tok_r.m[0];
            own_wr.pair = tok_r.m >> 1;
            own_wr.node = tok_r.e;
            done        = 1'b1;
          end else begin
            if (swap) begin
              own_wr.en   = 1'b1;
              own_wr.side = tok_r.m[0];
              own_wr.pair = tok_r.m >> 1;
              own_wr.node = tok_r.e;
            end
            tok_out.valid   = 1'b1;
            tok_out.op      = OP_INS;
            tok_out.started = swap;
            tok_out.sh      = tok_r.sh - 1'b1;
            tok_out.m       = tok_r.mfin >> (tok_r.sh - 1'b1);
            tok_out.mfin    = tok_r.mfin;
            tok_out.n       = tok_r.n;
            tok_out.e       = swap ? node_x : tok_r.e;
          end
        end
        OP_SIFT: begin
          up_out.en   = 1'b1;
          up_out.side = tok_r.m[0];
          up_out.pair = tok_r.m >> 1;
          if (has_l && (tok_r.e.expiry > child.expiry)) begin
            up_out.node = child;
            if (((NODE_W + 2)'(c) << 1) <= ext_n) begin
              tok_out.valid = 1'b1;
              tok_out.op    = OP_SIFT;
              tok_out.m     = c;
              tok_out.mfin  = tok_r.mfin;
              tok_out.n     = tok_r.n;
              tok_out.e     = tok_r.e;
            end else begin
              own_wr.en   = 1'b1;
              own_wr.side = use_r;
              own_wr.pair = tok_r.m;
              own_wr.node = tok_r.e;
              done        = 1'b1;
            end
          end else begin
            up_out.node = tok_r.e;
            done        = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/mhtq_ctrl.sv =====
// Command sequencer: count, root copy, cancel flag RAM, result register.
// Drives insert and sift work into the level chain. Uses mhtq_pkg and mhtq_ram.
module mhtq_ctrl
  import mhtq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_BITS-1:0]  in_cmd,
  input  logic [ID_BITS-1:0]   in_timer_id,
  input  logic [TIME_BITS-1:0] in_delay,
  input  logic [TIME_BITS-1:0] in_now,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [ID_BITS-1:0]   out_expired_id,
  output logic                 out_fired,
  output logic                 out_status,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic [TIME_BITS-1:0] out_earliest_expiry,
  output logic                 out_last,
  output tok_t                 ins_tok,
  output tok_t                 sift_tok,
  output logic [NODE_W-1:0]    probe_m,
  input  entry_t               probe_node,
  input  logic                 done,
  input  wreq_t                root_wr
);

  state_t               state_r;
  state_t               state_nxt;
  logic [CMD_BITS-1:0]  cmd_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 full_r;
  logic [CNT_W-1:0]     count_r;
  entry_t               root_r;
  logic [ID_BITS-1:0]   pid_r;
  logic                 fired_r;
  logic [FLAG_AW-1:0]   clr_r;

  logic                 accept;
  logic                 full_now;
  logic                 in_id_ok;
  logic                 pid_ok;
  logic                 due;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] add_exp;
  logic [NODE_W-1:0]    mfin;

  logic                 flag_we;
  logic [FLAG_AW-1:0]   flag_waddr;
  logic                 flag_wdata;
  logic [FLAG_AW-1:0]   flag_raddr;
  logic                 flag_rd;

  logic                 emit;
  logic                 emit_kind;
  logic [ID_BITS-1:0]   emit_id;
  logic                 emit_fired;
  logic                 emit_status;
  logic [TIME_BITS-1:0] emit_earliest;
  logic                 emit_last;

  logic                 out_valid_r;
  logic                 out_kind_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic                 out_fired_r;
  logic                 out_status_r;
  logic [CNT_W-1:0]     out_count_r;
  logic [TIME_BITS-1:0] out_earliest_r;
  logic                 out_last_r;

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && (state_r == S_IDLE);
  assign full_now = (count_r == CNT_W'(CAPACITY));
  assign in_id_ok = (32'(in_timer_id) < ID_COUNT);
  assign pid_ok   = (32'(root_r.ident) < ID_COUNT);
  assign due      = (count_r != '0) && (root_r.expiry <= now_r);
  assign sum      = {1'b0, in_now} + {1'b0, in_delay};
  assign add_exp  = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  assign mfin     = NODE_W'(count_r) + NODE_W'(1);
  assign probe_m  = NODE_W'(count_r) + NODE_W'(1);

  assign flag_we    = (state_r == S_CLR) ||
                      (accept && in_id_ok &&
                       ((in_cmd == CMD_CANCEL) || ((in_cmd == CMD_ADD) && !full_now)));
  assign flag_waddr = (state_r == S_CLR) ? clr_r : FLAG_AW'(in_timer_id);
  assign flag_wdata = (state_r != S_CLR) && (in_cmd == CMD_CANCEL);
  assign flag_raddr = FLAG_AW'(root_r.ident);

  mhtq_ram #(
    .WIDTH (1),
    .DEPTH (ID_COUNT)
  ) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .raddr (flag_raddr),
    .rdata (flag_rd)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == FLAG_AW'(ID_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_ADD:    state_nxt = full_now ? S_ACK : S_WAIT;
            CMD_CANCEL: state_nxt = S_ACK;
            CMD_TICK:   state_nxt = S_TCHK;
            default:    state_nxt = S_ACK;
          endcase
        end
      end
      S_ACK:   state_nxt = S_IDLE;
      S_WAIT: begin
        if (done) begin
          state_nxt = (cmd_r == CMD_TICK) ? S_POP : S_ACK;
        end
      end
      S_TCHK: begin
        if (!due) begin
          state_nxt = S_ACK;
        end else if (count_r == CNT_W'(1)) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_INJ;
      S_INJ:   state_nxt = S_WAIT;
      S_POP:   state_nxt = due ? S_TCHK : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit          = 1'b0;
    emit_kind     = 1'b0;
    emit_id       = '0;
    emit_fired    = 1'b0;
    emit_status   = 1'b0;
    emit_last     = 1'b0;
    emit_earliest = (count_r != '0) ? root_r.expiry : '0;
    ins_tok       = '0;
    sift_tok      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == CMD_ADD) && !full_now) begin
          ins_tok.valid    = 1'b1;
          ins_tok.op       = OP_INS;
          ins_tok.sh       = lvl_of(mfin);
          ins_tok.m        = NODE_W'(1);
          ins_tok.mfin     = mfin;
          ins_tok.n        = count_r;
          ins_tok.e.expiry = add_exp;
          ins_tok.e.ident  = in_timer_id;
        end
      end
      S_ACK: begin
        emit        = 1'b1;
        emit_status = full_r;
        emit_last   = 1'b1;
      end
      S_INJ: begin
        sift_tok.valid = 1'b1;
        sift_tok.op    = OP_SIFT;
        sift_tok.m     = NODE_W'(1);
        sift_tok.mfin  = NODE_W'(1);
        sift_tok.n     = count_r;
        sift_tok.e     = probe_node;
      end
      S_POP: begin
        emit       = 1'b1;
        emit_kind  = 1'b1;
        emit_id    = pid_r;
        emit_fired = fired_r;
        emit_last  = !due;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + FLAG_AW'(1);
      end
      if (accept && (in_cmd == CMD_ADD) && !full_now) begin
        count_r <= count_r + CNT_W'(1);
      end else if ((state_r == S_TCHK) && due) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      now_r  <= in_now;
      full_r <= (in_cmd == CMD_ADD) && full_now;
    end
    if (root_wr.en && root_wr.side) begin
      root_r <= root_wr.node;
    end
    if (state_r == S_TCHK) begin
      pid_r   <= root_r.ident;
      fired_r <= !(pid_ok && flag_rd);
    end
    out_kind_r     <= emit_kind;
    out_id_r       <= emit_id;
    out_fired_r    <= emit_fired;
    out_status_r   <= emit_status;
    out_count_r    <= count_r;
    out_earliest_r <= emit_earliest;
    out_last_r     <= emit_last;
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_expired_id      = out_id_r;
  assign out_fired           = out_fired_r;
  assign out_status          = out_status_r;
  assign out_entry_count     = out_count_r;
  assign out_earliest_expiry = out_earliest_r;
  assign out_last            = out_last_r;

endmodule

// ===== rtl/min_heap_timer_queue.sv =====
// Timer queue as a min-heap, one cell per level; uses mhtq_pkg, mhtq_ram, mhtq_cell, mhtq_ctrl.
// Add: the result follows the insert's walk down to the level of the new leaf (0..6). Cancel, unknown: one beat.
// Tick: one result beat when nothing is due; else one beat per pop, each pop waiting for its
// sift-down walk (none when it empties the heap); busy drops with the last beat.
// One command at a time; the receiver cannot stall. Reset clears the count, then holds busy
// high while the ID_COUNT (256) cancel flags clear; heap RAMs are not cleared.
module min_heap_timer_queue
  import mhtq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_BITS-1:0]  in_cmd,
  input  logic [ID_BITS-1:0]   in_timer_id,
  input  logic [TIME_BITS-1:0] in_delay,
  input  logic [TIME_BITS-1:0] in_now,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [ID_BITS-1:0]   out_expired_id,
  output logic                 out_fired,
  output logic                 out_status,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic [TIME_BITS-1:0] out_earliest_expiry,
  output logic                 out_last
);

  tok_t              ins_tok;
  tok_t              sift_tok;
  logic [NODE_W-1:0] probe_m;
  entry_t            probe_node;
  logic              done;

  tok_t              tok_in  [NUM_LEVELS];
  tok_t              tok_out [NUM_LEVELS];
  wreq_t             up_in   [NUM_LEVELS];
  wreq_t             up_out  [NUM_LEVELS];
  ramreq_t           rq      [NUM_LEVELS];
  entry_t            rdl     [NUM_LEVELS];
  entry_t            rdr     [NUM_LEVELS];
  entry_t            pnode   [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] done_v;

  assign done       = |done_v;
  assign probe_node = pnode[lvl_of(probe_m)];

  mhtq_ctrl u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_timer_id         (in_timer_id),
    .in_delay            (in_delay),
    .in_now              (in_now),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_expired_id      (out_expired_id),
    .out_fired           (out_fired),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_earliest_expiry (out_earliest_expiry),
    .out_last            (out_last),
    .ins_tok             (ins_tok),
    .sift_tok            (sift_tok),
    .probe_m             (probe_m),
    .probe_node          (probe_node),
    .done                (done),
    .root_wr             (rq[0].wr)
  );

  for (genvar L = 0; L < NUM_LEVELS; L++) begin : g_lvl
    localparam int LDEPTH = (L < 2) ? 1 : (1 << (L - 1));
    localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;

    logic [LAW-1:0] raddr;
    logic [LAW-1:0] waddr;

    if (L == 0) begin : g_first
      assign tok_in[L] = ins_tok;
    end else if (L == 1) begin : g_second
      assign tok_in[L] = sift_tok.valid ? sift_tok : tok_out[L-1];
    end else begin : g_mid
      assign tok_in[L] = tok_out[L-1];
    end

    if (L == NUM_LEVELS - 1) begin : g_last
      assign up_in[L] = '0;
    end else begin : g_up
      assign up_in[L] = up_out[L+1];
    end

    if (L < 2) begin : g_addr0
      assign raddr = '0;
      assign waddr = '0;
    end else begin : g_addr
      assign raddr = rq[L].raddr[LAW-1:0];
      assign waddr = rq[L].wr.pair[LAW-1:0];
    end

    mhtq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_in     (tok_in[L]),
      .tok_out    (tok_out[L]),
      .up_in      (up_in[L]),
      .up_out     (up_out[L]),
      .ram        (rq[L]),
      .rd_left    (rdl[L]),
      .rd_right   (rdr[L]),
      .probe_m    (probe_m),
      .probe_node (pnode[L]),
      .done       (done_v[L])
    );

    mhtq_ram #(
      .WIDTH ($bits(entry_t)),
      .DEPTH (LDEPTH)
    ) u_ram_l (
      .clk   (clk),
      .we    (rq[L].wr.en && !rq[L].wr.side),
      .waddr (waddr),
      .wdata (rq[L].wr.node),
      .raddr (raddr),
      .rdata (rdl[L])
    );

    mhtq_ram #(
      .WIDTH ($bits(entry_t)),
      .DEPTH (LDEPTH)
    ) u_ram_r (
      .clk   (clk),
      .we    (rq[L].wr.en && rq[L].wr.side),
      .waddr (waddr),
      .wdata (rq[L].wr.node),
      .raddr (raddr),
      .rdata (rdr[L])
    );
  end

endmodule

// ===== tb/min_heap_timer_queue_test.sv =====
// Testbench for min_heap_timer_queue: drives add, cancel, tick and unused commands and
// checks every result beat against a timer heap kept in the bench.
// Depends on mhtq_pkg and the min_heap_timer_queue RTL.
`timescale 1ns / 1ps

module min_heap_timer_queue_test;
  import mhtq_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = CMD_BITS'(3);
  localparam int MAX_CYCLES = 1000000;
  localparam int MAX_SHOWN  = 10;

  typedef struct packed {
    logic                 kind;
    logic [ID_BITS-1:0]   ident;
    logic                 fired;
    logic                 status;
    logic [CNT_W-1:0]     count;
    logic [TIME_BITS-1:0] earliest;
    logic                 last;
  } timer_report_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_BITS-1:0]  in_cmd;
  logic [ID_BITS-1:0]   in_timer_id;
  logic [TIME_BITS-1:0] in_delay;
  logic [TIME_BITS-1:0] in_now;
  logic                 out_valid;
  logic                 out_kind;
  logic [ID_BITS-1:0]   out_expired_id;
  logic                 out_fired;
  logic                 out_status;
  logic [CNT_W-1:0]     out_entry_count;
  logic [TIME_BITS-1:0] out_earliest_expiry;
  logic                 out_last;

  logic [TIME_BITS-1:0] heap_key [CAPACITY];
  logic [ID_BITS-1:0]   heap_tag [CAPACITY];
  bit                   cancelled [ID_COUNT];
  int                   held;

  timer_report_t        queued_reports [$];
  timer_report_t        got_report;
  timer_report_t        want_report;
  int                   mismatches;
  int                   cycles;
  int                   idle_pct;
  logic [TIME_BITS-1:0] time_base;

  min_heap_timer_queue dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_timer_id         (in_timer_id),
    .in_delay            (in_delay),
    .in_now              (in_now),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_expired_id      (out_expired_id),
    .out_fired           (out_fired),
    .out_status          (out_status),
    .out_entry_count     (out_entry_count),
    .out_earliest_expiry (out_earliest_expiry),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic timer_report_t make_report(input logic kind, input logic [ID_BITS-1:0] id,
                                                input logic fired, input logic status,
                                                input logic last);
    timer_report_t r;
    r.kind     = kind;
    r.ident    = id;
    r.fired    = fired;
    r.status   = status;
    r.count    = CNT_W'(held);
    r.earliest = (held > 0) ? heap_key[0] : '0;
    r.last     = last;
    return r;
  endfunction

  task automatic drop_earliest();
    int                   pos;
    int                   c;
    logic [TIME_BITS-1:0] key;
    logic [ID_BITS-1:0]   tag;
    pos = 0;
    held--;
    if (held > 0) begin
      key = heap_key[held];
      tag = heap_tag[held];
      forever begin
        c = 2 * pos + 1;
        if (c >= held) break;
        if (c + 1 < held && heap_key[c + 1] < heap_key[c]) c++;
        if (key <= heap_key[c]) break;
        heap_key[pos] = heap_key[c];
        heap_tag[pos] = heap_tag[c];
        pos = c;
      end
      heap_key[pos] = key;
      heap_tag[pos] = tag;
    end
  endtask

  task automatic apply_timer_cmd(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                                 input logic [TIME_BITS-1:0] delay,
                                 input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] key;
    logic [ID_BITS-1:0]   tag;
    int                   pos;
    int                   up;
    int                   n;
    timer_report_t        prev;
    case (cmd)
      CMD_ADD: begin
        if (held >= CAPACITY) begin
          queued_reports.push_back(make_report(1'b0, '0, 1'b0, 1'b1, 1'b1));
        end else begin
          sum = {1'b0, now} + {1'b0, delay};
          key = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
          cancelled[id] = 1'b0;
          pos = held;
          while (pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_key[up] <= key) break;
            heap_key[pos] = heap_key[up];
            heap_tag[pos] = heap_tag[up];
            pos = up;
          end
          heap_key[pos] = key;
          heap_tag[pos] = id;
          held++;
          queued_reports.push_back(make_report(1'b0, '0, 1'b0, 1'b0, 1'b1));
        end
      end
      CMD_CANCEL: begin
        cancelled[id] = 1'b1;
        queued_reports.push_back(make_report(1'b0, '0, 1'b0, 1'b0, 1'b1));
      end
      CMD_TICK: begin
        n = 0;
        while (held > 0 && heap_key[0] <= now) begin
          tag = heap_tag[0];
          drop_earliest();
          if (n > 0) queued_reports.push_back(prev);
          prev = make_report(1'b1, tag, !cancelled[tag], 1'b0, 1'b0);
          n++;
        end
        if (n == 0) begin
          queued_reports.push_back(make_report(1'b0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          prev.last = 1'b1;
          queued_reports.push_back(prev);
        end
      end
      default: begin
        queued_reports.push_back(make_report(1'b0, '0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic send_cmd(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id,
                          input logic [TIME_BITS-1:0] delay,
                          input logic [TIME_BITS-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start       = 1'b1;
    in_cmd      = cmd;
    in_timer_id = id;
    in_delay    = delay;
    in_now      = now;
    do begin
      @(posedge clk);
    end while (busy);
    apply_timer_cmd(cmd, id, delay, now);
  endtask

  task automatic wait_all_reported();
    @(negedge clk);
    start = 1'b0;
    while (queued_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    idle_pct = 0;
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'd0);
    send_cmd(CMD_ADD,    8'd0,   32'd0,          32'd100);
    send_cmd(CMD_ADD,    8'd255, 32'd5,          32'd100);
    send_cmd(CMD_ADD,    8'd7,   32'hFFFF_FFFF,  32'd100);
    send_cmd(CMD_ADD,    8'd8,   32'h8000_0000,  32'h8000_0000);
    send_cmd(CMD_ADD,    8'd9,   32'd5,          32'd100);
    send_cmd(CMD_ADD,    8'd10,  32'd5,          32'd100);
    send_cmd(CMD_CANCEL, 8'd255, 32'd0,          32'd0);
    send_cmd(CMD_CANCEL, 8'd3,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_cmd(CMD_UNUSED, 8'hAA,  32'h5555_5555,  32'hAAAA_AAAA);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'd99);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'd100);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'd105);
    send_cmd(CMD_ADD,    8'd255, 32'd1,          32'd110);
    send_cmd(CMD_ADD,    8'd12,  32'd0,          32'd110);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'd111);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'hFFFF_FFFE);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'hFFFF_FFFF);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'hFFFF_FFFF);
    send_cmd(CMD_ADD,    8'd1,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_cmd(CMD_TICK,   8'd0,   32'd0,          32'hFFFF_FFFF);
  endtask

  task automatic test_full_heap();
    idle_pct = 30;
    while (held < CAPACITY) begin
      send_cmd(CMD_ADD, ID_BITS'($urandom), 32'($urandom_range(50)), 32'd1000);
    end
    send_cmd(CMD_ADD, 8'd200, 32'd0, 32'd1000);
    send_cmd(CMD_ADD, ID_BITS'($urandom), $urandom, $urandom);
    send_cmd(CMD_CANCEL, heap_tag[$urandom_range(CAPACITY - 1)], 32'd0, 32'd0);
    send_cmd(CMD_CANCEL, heap_tag[0], 32'd0, 32'd0);
    send_cmd(CMD_TICK, 8'd0, 32'd0, 32'd2000);
    send_cmd(CMD_TICK, 8'd0, 32'd0, 32'd2000);
  endtask

  task automatic test_random_traffic(input int items, input int pct);
    int                   r;
    logic [CMD_BITS-1:0]  cmd;
    logic [ID_BITS-1:0]   id;
    logic [TIME_BITS-1:0] dly;
    logic [TIME_BITS-1:0] now;
    idle_pct  = pct;
    time_base = $urandom >> $urandom_range(31);
    repeat (items) begin
      r   = $urandom_range(99);
      cmd = (r < 50) ? CMD_ADD : (r < 65) ? CMD_CANCEL : (r < 95) ? CMD_TICK : CMD_UNUSED;
      id  = ($urandom_range(3) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(15));
      case ($urandom_range(9))
        0:       dly = $urandom;
        1:       dly = 32'hFFFF_FFFF - $urandom_range(15);
        default: dly = $urandom_range(40);
      endcase
      time_base = time_base + $urandom_range(6);
      now = ($urandom_range(19) == 0) ? $urandom : time_base;
      send_cmd(cmd, id, dly, now);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_report = '{out_kind, out_expired_id, out_fired, out_status, out_entry_count,
                     out_earliest_expiry, out_last};
      if (queued_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected beat: kind=%0d id=%0d fired=%0d status=%0d cnt=%0d exp=%h last=%0d",
                   got_report.kind, got_report.ident, got_report.fired, got_report.status,
                   got_report.count, got_report.earliest, got_report.last);
        end
      end else begin
        want_report = queued_reports.pop_front();
        if (got_report !== want_report) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch exp: kind=%0d id=%0d fired=%0d status=%0d cnt=%0d exp=%h last=%0d",
                     want_report.kind, want_report.ident, want_report.fired,
                     want_report.status, want_report.count, want_report.earliest,
                     want_report.last);
            $display("         got: kind=%0d id=%0d fired=%0d status=%0d cnt=%0d exp=%h last=%0d",
                     got_report.kind, got_report.ident, got_report.fired, got_report.status,
                     got_report.count, got_report.earliest, got_report.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_ADD;
    in_timer_id = '0;
    in_delay    = '0;
    in_now      = '0;
    held        = 0;
    mismatches  = 0;
    cycles      = 0;
    idle_pct    = 0;
    time_base   = '0;
    for (int i = 0; i < ID_COUNT; i++) cancelled[i] = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    wait_all_reported();
    test_full_heap();
    wait_all_reported();
    test_random_traffic(60, 0);
    test_random_traffic(60, 62);
    wait_all_reported();
    test_random_traffic(60, 0);
    test_random_traffic(60, 21);
    wait_all_reported();
    repeat (16) @(posedge clk);

    mismatches += queued_reports.size();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mhtq_pkg.sv
rtl/mhtq_ram.sv
rtl/mhtq_cell.sv
rtl/mhtq_ctrl.sv
rtl/min_heap_timer_queue.sv
tb/min_heap_timer_queue_test.sv
